// ===== hdl/fpe_pkg.sv =====
package fpe_pkg;

    localparam int INT_W              = 11;
    localparam int FRAC_W             = 20;
    localparam int REG_W              = 8;
    localparam int SCALE_SH           = 7;
    localparam int DVD_W              = FRAC_W + SCALE_SH;
    localparam int P1_W               = 18;
    localparam int DEF_BITS_PER_STAGE = 3;

    localparam logic [P1_W-1:0] P1_OFFSET = P1_W'(512);

    typedef struct packed {
        logic [INT_W-1:0]  ratio_integer;
        logic [FRAC_W-1:0] ratio_numerator;
        logic [FRAC_W-1:0] ratio_denominator;
        logic [REG_W-1:0]  first_register;
    } t_in;

    typedef struct packed {
        logic [7:0] start_register;
        logic [7:0] p3_mid_byte;
        logic [7:0] p3_low_byte;
        logic [1:0] p1_top_bits;
        logic [7:0] p1_mid_byte;
        logic [7:0] p1_low_byte;
        logic [7:0] shared_high_nibbles;
        logic [7:0] p2_mid_byte;
        logic [7:0] p2_low_byte;
        logic       divide_error;
    } t_out;

    // divider pipeline payload
    typedef struct packed {
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] num;
        logic [FRAC_W-1:0] den;
        logic [REG_W-1:0]  reg_num;
        logic [FRAC_W-1:0] rem;
        logic [DVD_W-1:0]  quo;
    } t_div;

endpackage

// ===== hdl/fpe_div_stage.sv =====
module fpe_div_stage #(
    parameter int P_MSB  = fpe_pkg::DVD_W - 1,
    parameter int P_BITS = fpe_pkg::DEF_BITS_PER_STAGE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fpe_pkg::t_div i_d,
    output logic          o_valid,
    output fpe_pkg::t_div o_d
);

    logic [fpe_pkg::DVD_W-1:0]  dvd;
    logic [fpe_pkg::FRAC_W-1:0] rem_c [P_BITS+1];
    logic [fpe_pkg::DVD_W-1:0]  quo_c [P_BITS+1];
    fpe_pkg::t_div              n_d;
    fpe_pkg::t_div              r_d;
    logic                       r_valid;

    assign dvd      = {i_d.num, fpe_pkg::SCALE_SH'(0)};
    assign rem_c[0] = i_d.rem;
    assign quo_c[0] = i_d.quo;

    // restoring division, one quotient bit per step
    for (genvar j = 0; j < P_BITS; j++) begin : g_step
        localparam int L_IDX = P_MSB - j;
        if (L_IDX >= 0) begin : g_bit
            localparam logic [fpe_pkg::DVD_W-1:0] L_MASK = fpe_pkg::DVD_W'(1) << L_IDX;
            logic [fpe_pkg::FRAC_W:0] trial;
            logic [fpe_pkg::FRAC_W:0] diff;
            logic                     fits;
            assign trial        = {rem_c[j], dvd[L_IDX]};
            assign diff         = trial - {1'b0, i_d.den};
            assign fits         = trial >= {1'b0, i_d.den};
            assign rem_c[j+1]   = fits ? diff[fpe_pkg::FRAC_W-1:0]
                                       : trial[fpe_pkg::FRAC_W-1:0];
            assign quo_c[j+1]   = fits ? (quo_c[j] | L_MASK) : quo_c[j];
        end else begin : g_pad
            assign rem_c[j+1] = rem_c[j];
            assign quo_c[j+1] = quo_c[j];
        end
    end

    always_comb begin
        n_d     = i_d;
        n_d.rem = rem_c[P_BITS];
        n_d.quo = quo_c[P_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_d <= n_d;
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

// ===== hdl/fpe_pack.sv =====
module fpe_pack (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fpe_pkg::t_div i_d,
    output logic          o_valid,
    output fpe_pkg::t_out o_result
);

    logic [fpe_pkg::P1_W-1:0]   p1;
    logic [fpe_pkg::FRAC_W-1:0] p2;
    logic [fpe_pkg::FRAC_W-1:0] p3;
    logic                       err;
    fpe_pkg::t_out              n_out;
    fpe_pkg::t_out              r_out;
    logic                       r_valid;

    assign err = (i_d.den == '0);
    assign p2  = i_d.rem;
    assign p3  = i_d.den;
    assign p1  = {i_d.int_part, fpe_pkg::SCALE_SH'(0)}
                 + i_d.quo[fpe_pkg::P1_W-1:0] - fpe_pkg::P1_OFFSET;

    always_comb begin
        n_out                = '0;
        n_out.start_register = i_d.reg_num;
        n_out.divide_error   = err;
        if (!err) begin
            n_out.p3_mid_byte         = p3[15:8];
            n_out.p3_low_byte         = p3[7:0];
            n_out.p1_top_bits         = p1[17:16];
            n_out.p1_mid_byte         = p1[15:8];
            n_out.p1_low_byte         = p1[7:0];
            n_out.shared_high_nibbles = {p3[19:16], p2[19:16]};
            n_out.p2_mid_byte         = p2[15:8];
            n_out.p2_low_byte         = p2[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_out <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/fractional_pll_param_encoder.sv =====
// an accepted beat passes through the registered divider stages and then the fpe_pack
// output register, which raises o_done together with the result
// throughput: one beat per cycle, busy is never raised; the pipeline depth is set by
// the 27-bit restoring divider, P_BITS_PER_STAGE compare-subtract steps per stage
// reset: synchronous active low, clears all stage valid bits; o_done stays low after it
module fractional_pll_param_encoder #(
    parameter int P_BITS_PER_STAGE = fpe_pkg::DEF_BITS_PER_STAGE
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  fpe_pkg::t_in  i_item,
    output logic          o_done,
    output fpe_pkg::t_out o_result
);

    localparam int L_NSTG    = (fpe_pkg::DVD_W + P_BITS_PER_STAGE - 1) / P_BITS_PER_STAGE;
    localparam int L_LATENCY = L_NSTG + 1;

    logic          stage_v [L_NSTG+1];
    fpe_pkg::t_div stage_d [L_NSTG+1];
    fpe_pkg::t_div in_d;

    assign busy = 1'b0;

    always_comb begin
        in_d          = '0;
        in_d.int_part = i_item.ratio_integer;
        in_d.num      = i_item.ratio_numerator;
        in_d.den      = i_item.ratio_denominator;
        in_d.reg_num  = i_item.first_register;
    end

    assign stage_v[0] = start && !busy;
    assign stage_d[0] = in_d;

    for (genvar s = 0; s < L_NSTG; s++) begin : g_stage
        fpe_div_stage #(
            .P_MSB  (fpe_pkg::DVD_W - 1 - s * P_BITS_PER_STAGE),
            .P_BITS (P_BITS_PER_STAGE)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_v[s]),
            .i_d     (stage_d[s]),
            .o_valid (stage_v[s+1]),
            .o_d     (stage_d[s+1])
        );
    end

    fpe_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_v[L_NSTG]),
        .i_d      (stage_d[L_NSTG]),
        .o_valid  (o_done),
        .o_result (o_result)
    );

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##L_LATENCY o_done)
        else $error("result beat missing after accepted beat");

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.divide_error) |->
            (o_result.p3_mid_byte == 8'h00 && o_result.p3_low_byte == 8'h00 &&
             o_result.p1_top_bits == 2'b00 && o_result.p1_mid_byte == 8'h00 &&
             o_result.p1_low_byte == 8'h00 && o_result.shared_high_nibbles == 8'h00 &&
             o_result.p2_mid_byte == 8'h00 && o_result.p2_low_byte == 8'h00))
        else $error("parameter bytes not cleared on divide error");

    a_p3_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.divide_error) |->
            (o_result.p3_mid_byte != 8'h00 || o_result.p3_low_byte != 8'h00 ||
             o_result.shared_high_nibbles[7:4] != 4'h0))
        else $error("zero denominator without divide error");

endmodule

// ===== sim/fpe_checker.sv =====
module fpe_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  fpe_pkg::t_in  i_item,
    input  logic          i_done,
    input  fpe_pkg::t_out i_result,
    output int            o_err_cnt,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SCALE = 128;
    localparam int P1_BIAS   = 512;

    fpe_pkg::t_out expected_params[$];
    int            err_cnt  = 0;
    int            pend_cnt = 0;

    assign o_err_cnt = err_cnt;
    assign o_pending = pend_cnt;

    function automatic fpe_pkg::t_out encode_ratio(input fpe_pkg::t_in ratio);
        fpe_pkg::t_out res;
        logic [63:0]   scaled;
        logic [63:0]   quot;
        logic [63:0]   rem;
        logic [63:0]   p1_sum;
        logic [17:0]   p1;
        logic [19:0]   p3;
        logic [19:0]   p2;
        res = '0;
        res.start_register = ratio.first_register;
        if (ratio.ratio_denominator == '0) begin
            res.divide_error = 1'b1;
            return res;
        end
        scaled = 64'(ratio.ratio_numerator) * NUM_SCALE;
        quot   = scaled / 64'(ratio.ratio_denominator);
        rem    = scaled % 64'(ratio.ratio_denominator);
        p1_sum = 64'(ratio.ratio_integer) * NUM_SCALE + quot - P1_BIAS;
        p1     = p1_sum[17:0];
        p3     = ratio.ratio_denominator;
        p2     = rem[19:0];
        res.p3_mid_byte         = p3[15:8];
        res.p3_low_byte         = p3[7:0];
        res.p1_top_bits         = p1[17:16];
        res.p1_mid_byte         = p1[15:8];
        res.p1_low_byte         = p1[7:0];
        res.shared_high_nibbles = {p3[19:16], p2[19:16]};
        res.p2_mid_byte         = p2[15:8];
        res.p2_low_byte         = p2[7:0];
        res.divide_error        = 1'b0;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        fpe_pkg::t_out exp_res;
        if (i_rst_n && i_done) begin
            if (expected_params.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result beat, expected none actual %0h",
                         $time, i_result);
            end else begin
                exp_res = expected_params.pop_front();
                check_field("start_register", exp_res.start_register,
                            i_result.start_register);
                check_field("p3_mid_byte", exp_res.p3_mid_byte, i_result.p3_mid_byte);
                check_field("p3_low_byte", exp_res.p3_low_byte, i_result.p3_low_byte);
                check_field("p1_top_bits", 8'(exp_res.p1_top_bits),
                            8'(i_result.p1_top_bits));
                check_field("p1_mid_byte", exp_res.p1_mid_byte, i_result.p1_mid_byte);
                check_field("p1_low_byte", exp_res.p1_low_byte, i_result.p1_low_byte);
                check_field("shared_high_nibbles", exp_res.shared_high_nibbles,
                            i_result.shared_high_nibbles);
                check_field("p2_mid_byte", exp_res.p2_mid_byte, i_result.p2_mid_byte);
                check_field("p2_low_byte", exp_res.p2_low_byte, i_result.p2_low_byte);
                check_field("divide_error", 8'(exp_res.divide_error),
                            8'(i_result.divide_error));
            end
        end
        if (i_rst_n && i_start && !i_busy) begin
            expected_params.push_back(encode_ratio(i_item));
        end
        pend_cnt = expected_params.size();
    end

endmodule

// ===== sim/tb_fractional_pll_param_encoder.sv =====
module tb_fractional_pll_param_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_GAP      = 17;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 100000;
    localparam logic [19:0] FRAC_MAX = 20'hFFFFF;

    typedef enum int {
        MIX_ZERO_DEN,
        MIX_SMALL_DEN,
        MIX_PROPER,
        MIX_FULL
    } t_mix;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic          busy;
    fpe_pkg::t_in  i_item  = '0;
    logic          o_done;
    fpe_pkg::t_out o_result;
    int            err_cnt;
    int            pending;
    int            cycle_cnt = 0;
    fpe_pkg::t_in  ratio_list[$];

    fractional_pll_param_encoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    fpe_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_item    (i_item),
        .i_done    (o_done),
        .i_result  (o_result),
        .o_err_cnt (err_cnt),
        .o_pending (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic fpe_pkg::t_in mk_ratio(input int a, input int b, input int c,
                                              input int r);
        fpe_pkg::t_in res;
        res.ratio_integer     = a[10:0];
        res.ratio_numerator   = b[19:0];
        res.ratio_denominator = c[19:0];
        res.first_register    = r[7:0];
        return res;
    endfunction

    function automatic fpe_pkg::t_in rand_ratio();
        fpe_pkg::t_in res;
        t_mix         mix;
        int           sel;
        sel = $urandom_range(0, 9);
        mix = (sel == 0) ? MIX_ZERO_DEN : (sel <= 2) ? MIX_SMALL_DEN :
              (sel <= 5) ? MIX_PROPER : MIX_FULL;
        res.ratio_integer   = 11'($urandom_range(0, 2047));
        res.ratio_numerator = 20'($urandom_range(0, FRAC_MAX));
        res.first_register  = 8'($urandom_range(0, 255));
        case (mix)
            MIX_ZERO_DEN: begin
                res.ratio_denominator = '0;
            end
            MIX_SMALL_DEN: begin
                res.ratio_denominator = 20'($urandom_range(1, 255));
            end
            MIX_PROPER: begin
                res.ratio_denominator = 20'($urandom_range(1, FRAC_MAX));
                res.ratio_numerator   = 20'($urandom_range(0, res.ratio_denominator - 1));
            end
            default: begin
                res.ratio_denominator = 20'($urandom_range(1, FRAC_MAX));
            end
        endcase
        return res;
    endfunction

    initial begin
        int gap;
        bit no_idle;
        // zero denominator
        ratio_list.push_back(mk_ratio(0, 0, 0, 0));
        ratio_list.push_back(mk_ratio(2047, FRAC_MAX, 0, 255));
        // p1 underflow and the boundary around zero
        ratio_list.push_back(mk_ratio(0, 0, 1, 16));
        ratio_list.push_back(mk_ratio(4, 0, 1, 1));
        ratio_list.push_back(mk_ratio(3, 127, 128, 2));
        ratio_list.push_back(mk_ratio(0, FRAC_MAX, FRAC_MAX, 9));
        // numerator not below denominator, with p1 overflow in most of these
        ratio_list.push_back(mk_ratio(2047, FRAC_MAX, 1, 3));
        ratio_list.push_back(mk_ratio(2047, FRAC_MAX, FRAC_MAX, 4));
        ratio_list.push_back(mk_ratio(0, FRAC_MAX, 1, 5));
        ratio_list.push_back(mk_ratio(1000, FRAC_MAX, 3, 10));
        // ordinary ratios and bit patterns
        ratio_list.push_back(mk_ratio(100, 5, 7, 6));
        ratio_list.push_back(mk_ratio(100, FRAC_MAX - 1, FRAC_MAX, 7));
        ratio_list.push_back(mk_ratio(35, 1, 3, 8));
        ratio_list.push_back(mk_ratio(1024, 20'h80000, FRAC_MAX, 8'hAA));
        ratio_list.push_back(mk_ratio(1365, 20'h55555, 20'hAAAAA, 8'h55));
        ratio_list.push_back(mk_ratio(682, 20'hAAAAA, 20'h55555, 8'hF0));
        ratio_list.push_back(mk_ratio(1, 1, 2, 8'h0F));
        ratio_list.push_back(mk_ratio(2047, 0, FRAC_MAX, 255));
        ratio_list.push_back(mk_ratio(36, 20'h80000, 20'h80001, 128));
        ratio_list.push_back(mk_ratio(2046, 20'hFFFFE, 20'h00001, 254));
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            ratio_list.push_back(rand_ratio());
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        no_idle = 1'b0;
        foreach (ratio_list[i]) begin
            if (i % 40 == 0) begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            start  <= 1'b1;
            i_item <= ratio_list[i];
            do @(posedge i_clk); while (busy);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
